// ===== hdl/assert_macros.svh =====
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that must hold at every edge outside reset.
`define KCP_ASSERT_ALWAYS(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Condition in one cycle that forces another in the next.
`define KCP_ASSERT_NEXT(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

// ===== hdl/kcp_pkg.sv =====
`timescale 1ns / 1ps

package kcp_pkg;

   localparam int KEY_LEN     = 8;
   localparam int IDX_W       = $clog2(KEY_LEN);
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef logic [7:0] byte_type;

   // One finished row handed from the collector to the emitter.
   typedef struct packed {
      byte_type [KEY_LEN-1:0] bytes;
      logic [IDX_W-1:0]       last_idx;  // index of the final valid byte
      logic                   last;      // message ends with this row
      logic                   permute;   // full row: emit in key order
   } row_desc_type;

endpackage

// ===== hdl/keyed_row_column_permuter_top.sv =====
`timescale 1ns / 1ps
// A row ends when full or at end of message; it is written into the queue,
// loaded into the emitter's row registers, and each byte is registered out.
// Throughput: one byte per cycle in and out while full is low and pop is high;
// the two-row queue between collector and emitter absorbs result-side stalls.
// Reset (synchronous, active high): empties queue and output, clears fill count
// and key; no clearing pass, accepts bytes in the first cycle after reset.

module keyed_row_column_permuter_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  logic [7:0]  req_char_in,
   input  logic        req_last_char,
   output logic        empty,
   input  logic        pop,
   output logic [7:0]  rsp_char_out,
   output logic        rsp_last_out,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [63:0] csr_key_bytes
);

   logic [63:0] key_ff;
   kcp_pkg::row_desc_type push_desc, head_desc;
   logic q_push, q_full, q_pop, q_empty;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff <= '0;
      end else if (csr_valid) begin
         key_ff <= csr_key_bytes;
      end
   end

   kcp_front u_front (
      .clock         (clock),
      .reset         (reset),
      .push          (push),
      .full          (full),
      .req_char_in   (req_char_in),
      .req_last_char (req_last_char),
      .q_full        (q_full),
      .q_push        (q_push),
      .q_desc        (push_desc)
   );

   kcp_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (q_push),
      .din   (push_desc),
      .full  (q_full),
      .pop   (q_pop),
      .dout  (head_desc),
      .empty (q_empty)
   );

   kcp_back u_back (
      .clock        (clock),
      .reset        (reset),
      .key_bytes    (key_ff),
      .q_desc       (head_desc),
      .q_empty      (q_empty),
      .q_pop        (q_pop),
      .empty        (empty),
      .pop          (pop),
      .rsp_char_out (rsp_char_out),
      .rsp_last_out (rsp_last_out)
   );

endmodule

// ===== hdl/kcp_front.sv =====
`timescale 1ns / 1ps

module kcp_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   output logic                  full,
   input  logic [7:0]            req_char_in,
   input  logic                  req_last_char,
   input  logic                  q_full,
   output logic                  q_push,
   output kcp_pkg::row_desc_type q_desc
);

   kcp_pkg::byte_type [kcp_pkg::KEY_LEN-1:0] row_ff, row_in;
   logic [kcp_pkg::IDX_W-1:0] fill_ff, fill_in;
   logic accept;
   logic row_full;
   logic row_done;

   assign full     = q_full;
   assign accept   = push && !q_full;
   assign row_full = (fill_ff == kcp_pkg::IDX_W'(kcp_pkg::KEY_LEN - 1));
   assign row_done = row_full || req_last_char;

   always_comb begin
      row_in          = row_ff;
      row_in[fill_ff] = req_char_in;
      fill_in         = fill_ff;
      if (accept) begin
         fill_in = row_done ? '0 : fill_ff + 1'b1;
      end
   end

   assign q_push           = accept && row_done;
   assign q_desc.bytes     = row_in;
   assign q_desc.last_idx  = fill_ff;
   assign q_desc.last      = req_last_char;
   assign q_desc.permute   = row_full;

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else begin
         fill_ff <= fill_in;
      end
      if (accept) begin
         row_ff <= row_in;
      end
   end

endmodule

// ===== hdl/kcp_queue.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"

module kcp_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  kcp_pkg::row_desc_type din,
   output logic                  full,
   input  logic                  pop,
   output kcp_pkg::row_desc_type dout,
   output logic                  empty
);

   kcp_pkg::row_desc_type mem_ff [kcp_pkg::QUEUE_DEPTH];
   logic [kcp_pkg::QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [kcp_pkg::QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [kcp_pkg::QCNT_W-1:0] count_ff, count_in;
   logic do_push;
   logic do_pop;

   function automatic logic [kcp_pkg::QPTR_W-1:0] next_ptr(
      input logic [kcp_pkg::QPTR_W-1:0] ptr);
      if (ptr == kcp_pkg::QPTR_W'(kcp_pkg::QUEUE_DEPTH - 1))
         return '0;
      return ptr + 1'b1;
   endfunction

   assign full    = (count_ff == kcp_pkg::QCNT_W'(kcp_pkg::QUEUE_DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign dout    = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= din;
      end
   end

   `KCP_ASSERT_ALWAYS(a_no_push_when_full, clock, reset, !(push && full), "row pushed into full queue")
   `KCP_ASSERT_ALWAYS(a_no_pop_when_empty, clock, reset, !(pop && empty), "row popped from empty queue")
   `KCP_ASSERT_NEXT(a_count_tracks, clock, reset, do_push && !do_pop, !empty, "push left queue empty")

endmodule

// ===== hdl/kcp_back.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"

module kcp_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [63:0]           key_bytes,
   input  kcp_pkg::row_desc_type q_desc,
   input  logic                  q_empty,
   output logic                  q_pop,
   output logic                  empty,
   input  logic                  pop,
   output logic [7:0]            rsp_char_out,
   output logic                  rsp_last_out
);

   kcp_pkg::byte_type [kcp_pkg::KEY_LEN-1:0] row_ff;
   logic [kcp_pkg::KEY_LEN-1:0][kcp_pkg::IDX_W-1:0] map_ff, map_in;
   logic [kcp_pkg::KEY_LEN-1:0][kcp_pkg::IDX_W-1:0] rank;
   logic [kcp_pkg::KEY_LEN-1:0][kcp_pkg::IDX_W-1:0] key_map;
   logic [kcp_pkg::IDX_W-1:0] pos_ff, cnt_ff;
   logic busy_ff, last_ff;
   logic out_valid_ff;
   logic [7:0] out_char_ff;
   logic out_last_ff;
   logic emit, emit_last, load_en;

   // Stable ascending rank of each column: ties go to the lower column.
   always_comb begin
      logic [kcp_pkg::IDX_W:0] r;
      logic [7:0] ki, kd;
      for (int i = 0; i < kcp_pkg::KEY_LEN; i++) begin
         r  = '0;
         ki = key_bytes[8*i +: 8];
         for (int d = 0; d < kcp_pkg::KEY_LEN; d++) begin
            kd = key_bytes[8*d +: 8];
            if ((kd < ki) || ((kd == ki) && (d < i)))
               r = r + 1'b1;
         end
         rank[i] = r[kcp_pkg::IDX_W-1:0];
      end
   end

   // Invert ranks: output position p reads the column ranked p.
   always_comb begin
      key_map = '0;
      for (int p = 0; p < kcp_pkg::KEY_LEN; p++) begin
         for (int i = 0; i < kcp_pkg::KEY_LEN; i++) begin
            if (rank[i] == kcp_pkg::IDX_W'(p))
               key_map[p] = kcp_pkg::IDX_W'(i);
         end
      end
   end

   always_comb begin
      for (int p = 0; p < kcp_pkg::KEY_LEN; p++) begin
         map_in[p] = q_desc.permute ? key_map[p] : kcp_pkg::IDX_W'(p);
      end
   end

   assign emit      = busy_ff && (!out_valid_ff || pop);
   assign emit_last = emit && (pos_ff == cnt_ff);
   assign load_en   = !q_empty && (!busy_ff || emit_last);
   assign q_pop     = load_en;

   assign empty        = !out_valid_ff;
   assign rsp_char_out = out_char_ff;
   assign rsp_last_out = out_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         pos_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (load_en) begin
            busy_ff <= 1'b1;
            pos_ff  <= '0;
         end else if (emit_last) begin
            busy_ff <= 1'b0;
         end else if (emit) begin
            pos_ff <= pos_ff + 1'b1;
         end
         if (emit) begin
            out_valid_ff <= 1'b1;
         end else if (pop) begin
            out_valid_ff <= 1'b0;
         end
      end
      if (load_en) begin
         row_ff  <= q_desc.bytes;
         map_ff  <= map_in;
         cnt_ff  <= q_desc.last_idx;
         last_ff <= q_desc.last;
      end
      if (emit) begin
         out_char_ff <= row_ff[map_ff[pos_ff]];
         out_last_ff <= last_ff && (pos_ff == cnt_ff);
      end
   end

   `KCP_ASSERT_ALWAYS(a_pos_in_row, clock, reset, !busy_ff || (pos_ff <= cnt_ff), "position beyond row")
   `KCP_ASSERT_NEXT(a_emit_fills_slot, clock, reset, emit, out_valid_ff, "emitted byte not held")
   `KCP_ASSERT_NEXT(a_mid_row_advance, clock, reset, emit && !emit_last, busy_ff && (pos_ff == $past(pos_ff) + 1'b1), "row walk skipped")

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

   localparam int IDLE_LIMIT  = 2000;
   localparam int PHASES      = 8;
   localparam int PHASE_ITEMS = 50;
   localparam int SETTLE_CYC  = 6;

   typedef struct packed {
      kcp_pkg::byte_type ch;
      logic              last;
   } text_beat_type;

   typedef enum int {
      KEY_ZERO,
      KEY_ONES,
      KEY_RISING,
      KEY_FALLING,
      KEY_RANDOM,
      KEY_REPEATS,
      KEY_BINARY
   } key_kind_type;

   logic        clock;
   logic        reset;
   logic        push;
   logic        full;
   logic [7:0]  req_char_in;
   logic        req_last_char;
   logic        empty;
   logic        pop;
   logic [7:0]  rsp_char_out;
   logic        rsp_last_out;
   logic        csr_valid;
   logic        csr_ready;
   logic [63:0] csr_key_bytes;

   text_beat_type plain_q[$];
   text_beat_type cipher_due[$];

   // shadow of the block: key, partial row and its fill
   logic [63:0]       key_held = '0;
   kcp_pkg::byte_type row_held [kcp_pkg::KEY_LEN];
   int                fill_held = 0;

   int          req_left = 0;
   int          req_gap = 0;
   int          rsp_gap = 0;
   int          idle_cycles = 0;
   int          mismatches = 0;
   bit          req_done = 0;
   bit          rsp_done = 0;
   bit          csr_done = 0;
   bit          req_burst = 0;
   bit          rsp_burst = 0;

   keyed_row_column_permuter_top DUT (
      .clock         (clock),
      .reset         (reset),
      .push          (push),
      .full          (full),
      .req_char_in   (req_char_in),
      .req_last_char (req_last_char),
      .empty         (empty),
      .pop           (pop),
      .rsp_char_out  (rsp_char_out),
      .rsp_last_out  (rsp_last_out),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_key_bytes (csr_key_bytes)
   );

   always #4 clock = ~clock;

   function automatic logic [63:0] make_key(key_kind_type kind);
      logic [63:0]       k;
      kcp_pkg::byte_type b;
      k = '0;
      for (int i = 0; i < 8; i++) begin
         case (kind)
            KEY_ZERO:    b = 8'h00;
            KEY_ONES:    b = 8'hFF;
            KEY_RISING:  b = 8'(8'h41 + i);
            KEY_FALLING: b = 8'(8'h5A - i);
            KEY_REPEATS: b = 8'(8'h61 + $urandom_range(0, 2));
            KEY_BINARY:  b = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            default:     b = 8'($urandom_range(0, 255));
         endcase
         k[8*i +: 8] = b;
      end
      return k;
   endfunction

   // stable ascending rank: ties go to the lower column
   function automatic int col_rank(int col);
      int                r;
      kcp_pkg::byte_type kc;
      kcp_pkg::byte_type kd;
      r = 0;
      kc = key_held[8*col +: 8];
      for (int d = 0; d < kcp_pkg::KEY_LEN; d++) begin
         kd = key_held[8*d +: 8];
         if (kd < kc || (kd == kc && d < col))
            r++;
      end
      return r;
   endfunction

   task automatic encipher(kcp_pkg::byte_type ch, logic last);
      kcp_pkg::byte_type perm [kcp_pkg::KEY_LEN];
      text_beat_type     beat;
      int                n;
      row_held[fill_held] = ch;
      n = fill_held + 1;
      if (n == kcp_pkg::KEY_LEN) begin
         for (int c = 0; c < kcp_pkg::KEY_LEN; c++)
            perm[col_rank(c)] = row_held[c];
         for (int p = 0; p < kcp_pkg::KEY_LEN; p++) begin
            beat.ch = perm[p];
            beat.last = last && (p == kcp_pkg::KEY_LEN - 1);
            cipher_due.push_back(beat);
         end
         fill_held = 0;
      end else if (last) begin
         // short final row leaves in arrival order
         for (int i = 0; i < n; i++) begin
            beat.ch = row_held[i];
            beat.last = (i == n - 1);
            cipher_due.push_back(beat);
         end
         fill_held = 0;
      end else begin
         fill_held = n;
      end
   endtask

   task automatic check_cipher(kcp_pkg::byte_type ch, logic last);
      text_beat_type due;
      if (cipher_due.size() == 0) begin
         mismatches++;
         if (mismatches <= 10)
            $display("unexpected byte %02h last %0b at %0t", ch, last, $realtime);
      end else begin
         due = cipher_due.pop_front();
         if (ch !== due.ch || last !== due.last) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch at %0t: expected %02h last %0b, got %02h last %0b",
                        $realtime, due.ch, due.last, ch, last);
         end
      end
   endtask

   task automatic queue_char(kcp_pkg::byte_type ch, logic last);
      text_beat_type beat;
      beat.ch = ch;
      beat.last = last;
      plain_q.push_back(beat);
      req_left++;
   endtask

   task automatic settle();
      do @(negedge clock); while (req_left != 0 || cipher_due.size() != 0);
      repeat (SETTLE_CYC) @(negedge clock);
   endtask

   task automatic write_key(logic [63:0] value);
      csr_done = 0;
      @(negedge clock);
      csr_key_bytes <= value;
      csr_valid <= 1'b1;
      do @(negedge clock); while (!csr_done);
      csr_valid <= 1'b0;
   endtask

   // rising edge: every transfer is seen here
   always @(posedge clock) begin : sample_edge
      bit moved;
      moved = 0;
      if (!reset) begin
         if (push && !full) begin
            encipher(req_char_in, req_last_char);
            req_left--;
            req_done = 1;
            moved = 1;
         end
         if (pop && !empty) begin
            check_cipher(rsp_char_out, rsp_last_out);
            rsp_done = 1;
            moved = 1;
         end
         if (csr_valid && csr_ready) begin
            key_held = csr_key_bytes;
            csr_done = 1;
            moved = 1;
         end
         idle_cycles = moved ? 0 : idle_cycles + 1;
      end
   end

   always @(negedge clock) begin : drive_plain
      text_beat_type beat;
      if (!push || req_done) begin
         req_done = 0;
         if (req_gap > 0) begin
            push <= 1'b0;
            req_gap--;
         end else if (plain_q.size() > 0) begin
            beat = plain_q.pop_front();
            req_char_in <= beat.ch;
            req_last_char <= beat.last;
            push <= 1'b1;
            if ($urandom_range(0, 31) == 0)
               req_burst = !req_burst;
            req_gap = req_burst ? 0 : $urandom_range(0, 5);
         end else begin
            push <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin : drain_cipher
      if (rsp_done) begin
         rsp_done = 0;
         if ($urandom_range(0, 31) == 0)
            rsp_burst = !rsp_burst;
         rsp_gap = rsp_burst ? 0 : $urandom_range(0, 5);
      end
      if (rsp_gap > 0) begin
         pop <= 1'b0;
         rsp_gap--;
      end else begin
         pop <= 1'b1;
      end
   end

   initial begin : watchdog
      while (idle_cycles < IDLE_LIMIT)
         @(posedge clock);
      $display("[FAIL] regression broken");
      $finish;
   end

   initial begin : stimulus
      kcp_pkg::byte_type corner_bytes [8];
      key_kind_type      kind;
      int                len;
      int                made;
      bit                open_end;

      clock = 1'b0;
      reset = 1'b1;
      push = 1'b0;
      pop = 1'b0;
      req_char_in = '0;
      req_last_char = 1'b0;
      csr_valid = 1'b0;
      csr_key_bytes = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reversing key; full row with no message end
      write_key(make_key(KEY_FALLING));
      corner_bytes = '{8'h00, 8'hFF, 8'h01, 8'h80, 8'h7F, 8'hFE, 8'h55, 8'hAA};
      for (int i = 0; i < 8; i++)
         queue_char(corner_bytes[i], 1'b0);
      // one-byte message
      queue_char(8'hFF, 1'b1);
      // key changed with a partial row held, then the row fills and ends the message
      queue_char(8'hC3, 1'b0);
      queue_char(8'h3C, 1'b0);
      queue_char(8'h00, 1'b0);
      settle();
      write_key(make_key(KEY_RANDOM));
      for (int i = 0; i < 5; i++)
         queue_char(8'($urandom_range(0, 255)), i == 4);
      // longest short row at message end
      for (int i = 0; i < kcp_pkg::KEY_LEN - 1; i++)
         queue_char(8'($urandom_range(0, 255)), i == kcp_pkg::KEY_LEN - 2);
      settle();

      for (int ph = 0; ph < PHASES; ph++) begin
         kind = (ph < 7) ? key_kind_type'(ph) : key_kind_type'($urandom_range(0, 6));
         write_key(make_key(kind));
         made = 0;
         while (made < PHASE_ITEMS) begin
            len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, kcp_pkg::KEY_LEN)
                                              : $urandom_range(1, 3 * kcp_pkg::KEY_LEN);
            // sometimes leave the message open across the key change
            open_end = (made + len >= PHASE_ITEMS) && (ph < PHASES - 1) &&
                       ($urandom_range(0, 2) == 0);
            for (int i = 0; i < len; i++)
               queue_char(8'($urandom_range(0, 255)), (i == len - 1) && !open_end);
            made += len;
         end
         settle();
      end

      repeat (8) @(negedge clock);
      if (mismatches == 0 && cipher_due.size() == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/kcp_pkg.sv
hdl/kcp_front.sv
hdl/kcp_queue.sv
hdl/kcp_back.sv
hdl/keyed_row_column_permuter_top.sv
tb/sv/tb_top.sv
